FILE: hdl/jbt_pkg.sv
package jbt_pkg;

	localparam int OffsetBits = 32;
	localparam int LengthBits = 16;
	localparam int MaxResults = 3;
	localparam int QueueDepth = 8;
	localparam int QueueAw = $clog2(QueueDepth);
	localparam int FillBits = $clog2(QueueDepth + 1);

	localparam logic [7:0] ChNul = 8'h00;
	localparam logic [7:0] ChQuote = 8'h22;
	localparam logic [7:0] ChDot = 8'h2E;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChLbrace = 8'h7B;
	localparam logic [7:0] ChRbrace = 8'h7D;
	localparam logic [7:0] ChLbracket = 8'h5B;
	localparam logic [7:0] ChRbracket = 8'h5D;
	localparam logic [7:0] ChComma = 8'h2C;
	localparam logic [7:0] ChColon = 8'h3A;

	typedef enum logic [3:0] {
		K_LBRACE = 4'd0,
		K_RBRACE = 4'd1,
		K_LBRACKET = 4'd2,
		K_RBRACKET = 4'd3,
		K_COMMA = 4'd4,
		K_COLON = 4'd5,
		K_STRING = 4'd6,
		K_NUMBER = 4'd7,
		K_TRUE = 4'd8,
		K_FALSE = 4'd9,
		K_NULL = 4'd10,
		K_UNKNOWN = 4'd11,
		K_END = 4'd12,
		K_ERROR = 4'd13
	} kind_t;

	typedef enum logic [5:0] {
		M_IDLE = 6'b000001,
		M_STRING = 6'b000010,
		M_NUMBER = 6'b000100,
		M_WORD = 6'b001000,
		M_ERROR = 6'b010000,
		M_DONE = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic end_of_text;
	} in_item_t;

	typedef struct packed {
		kind_t token_kind;
		logic [OffsetBits-1:0] token_start;
		logic [LengthBits-1:0] token_length;
		logic last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t [MaxResults-1:0] items;
	} push_t;

	typedef struct packed {
		logic hit;
		out_item_t tok;
	} pend_t;

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic [LengthBits-1:0] grow(input logic [LengthBits-1:0] ln);
		return (ln == {LengthBits{1'b1}}) ? ln : ln + LengthBits'(1);
	endfunction

	// Bit 0 tracks true, bit 1 false and bit 2 null.
	function automatic logic [2:0] word_flags(input logic [2:0] fl,
			input logic [LengthBits-1:0] ln, input logic [7:0] c);
		logic t_ok;
		logic f_ok;
		logic n_ok;
		t_ok = 1'b0;
		f_ok = 1'b0;
		n_ok = 1'b0;
		case (ln)
			LengthBits'(0): begin
				t_ok = (c == "t");
				f_ok = (c == "f");
				n_ok = (c == "n");
			end
			LengthBits'(1): begin
				t_ok = (c == "r");
				f_ok = (c == "a");
				n_ok = (c == "u");
			end
			LengthBits'(2): begin
				t_ok = (c == "u");
				f_ok = (c == "l");
				n_ok = (c == "l");
			end
			LengthBits'(3): begin
				t_ok = (c == "e");
				f_ok = (c == "s");
				n_ok = (c == "l");
			end
			LengthBits'(4): begin
				f_ok = (c == "e");
			end
			default: begin
				t_ok = 1'b0;
			end
		endcase
		return fl & {n_ok, f_ok, t_ok};
	endfunction

	function automatic kind_t word_kind(input logic [2:0] fl, input logic [LengthBits-1:0] ln);
		if (fl[0] && ln == LengthBits'(4))
			return K_TRUE;
		else if (fl[1] && ln == LengthBits'(5))
			return K_FALSE;
		else if (fl[2] && ln == LengthBits'(4))
			return K_NULL;
		return K_UNKNOWN;
	endfunction

	function automatic pend_t pending_token(input mode_t mode, input logic [2:0] fl,
			input logic [OffsetBits-1:0] st, input logic [LengthBits-1:0] ln);
		pend_t r;
		r.hit = 1'b1;
		r.tok.token_start = st;
		r.tok.token_length = ln;
		r.tok.last_of_run = 1'b0;
		unique case (mode)
			M_STRING: r.tok.token_kind = K_STRING;
			M_NUMBER: r.tok.token_kind = K_NUMBER;
			M_WORD: r.tok.token_kind = word_kind(fl, ln);
			default: begin
				r.hit = 1'b0;
				r.tok.token_kind = K_UNKNOWN;
			end
		endcase
		return r;
	endfunction

	function automatic out_item_t make_tok(input kind_t k, input logic [OffsetBits-1:0] st,
			input logic [LengthBits-1:0] ln);
		out_item_t r;
		r.token_kind = k;
		r.token_start = st;
		r.token_length = ln;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

FILE: hdl/jbt_if.sv
interface jbt_in_if;
	logic valid;
	logic ready;
	jbt_pkg::in_item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

interface jbt_out_if;
	logic valid;
	logic ready;
	jbt_pkg::out_item_t item;
	modport source(output valid, output item, input ready);
	modport sink(input valid, input item, output ready);
endinterface

FILE: hdl/json_byte_tokenizer.sv
// JSON byte tokenizer.
// The byte_ch channel carries one byte of JSON text per item, with end_of_text
// set on the final byte of a document. The token_ch channel carries token
// records: kind, start offset, length and last_of_run, which marks the final
// record caused by one byte. A byte causes from zero to three records.
// A byte accepted on byte_ch is registered and decoded from that register; its
// records are registered into the result queue, from which token_ch offers them.
// One byte is accepted per cycle while the eight-entry result queue has room
// for the records of the byte in decode and of the next one; the sustained
// rate is one byte per cycle whenever each byte gives at most one record and
// the receiver takes one record per cycle.
// When the receiver stalls, records wait in the queue and byte_ch.ready falls
// once fewer than six entries are free with a byte in decode, or fewer than
// three with none; nothing is dropped.
// Reset empties the queue and returns the scanner to the start of a document
// at offset zero. After the final byte the scanner resets itself in the same
// way, so the next byte begins a new document.
module json_byte_tokenizer (
	input logic clk,
	input logic arst_n,
	jbt_in_if.sink byte_ch,
	jbt_out_if.source token_ch
);

	logic busy_s1;
	logic take;
	logic [jbt_pkg::FillBits-1:0] fill;
	jbt_pkg::push_t push;

	assign byte_ch.ready = (fill + (busy_s1 ? jbt_pkg::FillBits'(jbt_pkg::MaxResults) : '0))
		<= jbt_pkg::FillBits'(jbt_pkg::QueueDepth - jbt_pkg::MaxResults);
	assign take = byte_ch.valid && byte_ch.ready;

	jbt_lexer u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.item(byte_ch.item),
		.busy_s1(busy_s1),
		.push(push)
	);

	jbt_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.fill(fill),
		.token_ch(token_ch)
	);

endmodule

FILE: hdl/jbt_lexer.sv
module jbt_lexer (
	input logic clk,
	input logic arst_n,
	input logic take,
	input jbt_pkg::in_item_t item,
	output logic busy_s1,
	output jbt_pkg::push_t push
);

	logic valid_s1;
	jbt_pkg::in_item_t item_s1;
	jbt_pkg::mode_t mode_q;
	logic [jbt_pkg::OffsetBits-1:0] pos_q;
	logic [jbt_pkg::OffsetBits-1:0] pstart_q;
	logic [jbt_pkg::LengthBits-1:0] plen_q;
	logic [2:0] flags_q;

	jbt_pkg::mode_t mode_d;
	logic [jbt_pkg::OffsetBits-1:0] pos_d;
	logic [jbt_pkg::OffsetBits-1:0] pstart_d;
	logic [jbt_pkg::LengthBits-1:0] plen_d;
	logic [2:0] flags_d;
	logic [1:0] cnt;
	jbt_pkg::out_item_t [jbt_pkg::MaxResults-1:0] items;

	always_comb begin
		logic [7:0] c;
		logic last;
		logic [jbt_pkg::OffsetBits-1:0] p;
		logic redo;
		jbt_pkg::pend_t pt;
		c = item_s1.text_byte;
		last = item_s1.end_of_text;
		p = pos_q;
		mode_d = mode_q;
		pstart_d = pstart_q;
		plen_d = plen_q;
		flags_d = flags_q;
		cnt = 2'd0;
		redo = 1'b0;
		pt = '0;
		items = '0;
		if (mode_q == jbt_pkg::M_DONE || mode_q == jbt_pkg::M_ERROR) begin
			if (last && mode_q == jbt_pkg::M_ERROR) begin
				items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_END, p, '0);
				cnt = cnt + 2'd1;
			end
		end else if (c == jbt_pkg::ChNul) begin
			pt = jbt_pkg::pending_token(mode_d, flags_d, pstart_d, plen_d);
			if (pt.hit) begin
				items[cnt] = pt.tok;
				cnt = cnt + 2'd1;
			end
			items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_END, p, '0);
			cnt = cnt + 2'd1;
			mode_d = jbt_pkg::M_DONE;
			pstart_d = '0;
			plen_d = '0;
			flags_d = 3'b111;
		end else begin
			unique case (mode_q) inside
				jbt_pkg::M_STRING: begin
					if (c == jbt_pkg::ChQuote) begin
						pt = jbt_pkg::pending_token(mode_d, flags_d, pstart_d, plen_d);
						items[cnt] = pt.tok;
						cnt = cnt + 2'd1;
						mode_d = jbt_pkg::M_IDLE;
						pstart_d = '0;
						plen_d = '0;
						flags_d = 3'b111;
					end else begin
						plen_d = jbt_pkg::grow(plen_d);
					end
				end
				jbt_pkg::M_NUMBER, jbt_pkg::M_WORD: begin
					if ((mode_q == jbt_pkg::M_NUMBER && (jbt_pkg::is_digit(c) || c == jbt_pkg::ChDot))
							|| (mode_q == jbt_pkg::M_WORD && jbt_pkg::is_alpha(c))) begin
						if (mode_q == jbt_pkg::M_WORD)
							flags_d = jbt_pkg::word_flags(flags_d, plen_d, c);
						plen_d = jbt_pkg::grow(plen_d);
					end else begin
						pt = jbt_pkg::pending_token(mode_d, flags_d, pstart_d, plen_d);
						items[cnt] = pt.tok;
						cnt = cnt + 2'd1;
						mode_d = jbt_pkg::M_IDLE;
						pstart_d = '0;
						plen_d = '0;
						flags_d = 3'b111;
						redo = 1'b1;
					end
				end
				default: begin
					redo = 1'b1;
				end
			endcase
			if (redo) begin
				unique case (c) inside
					jbt_pkg::ChLbrace, jbt_pkg::ChRbrace, jbt_pkg::ChLbracket,
					jbt_pkg::ChRbracket, jbt_pkg::ChComma, jbt_pkg::ChColon: begin
						unique case (c)
							jbt_pkg::ChLbrace: items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_LBRACE, p,
								jbt_pkg::LengthBits'(1));
							jbt_pkg::ChRbrace: items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_RBRACE, p,
								jbt_pkg::LengthBits'(1));
							jbt_pkg::ChLbracket: items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_LBRACKET,
								p, jbt_pkg::LengthBits'(1));
							jbt_pkg::ChRbracket: items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_RBRACKET,
								p, jbt_pkg::LengthBits'(1));
							jbt_pkg::ChComma: items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_COMMA, p,
								jbt_pkg::LengthBits'(1));
							default: items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_COLON, p,
								jbt_pkg::LengthBits'(1));
						endcase
						cnt = cnt + 2'd1;
					end
					jbt_pkg::ChQuote: begin
						pstart_d = p + jbt_pkg::OffsetBits'(1);
						plen_d = '0;
						flags_d = 3'b111;
						mode_d = jbt_pkg::M_STRING;
					end
					default: begin
						if (jbt_pkg::is_space(c)) begin
							mode_d = mode_d;
						end else if (jbt_pkg::is_digit(c) || c == jbt_pkg::ChMinus) begin
							pstart_d = p;
							plen_d = jbt_pkg::LengthBits'(1);
							flags_d = 3'b111;
							mode_d = jbt_pkg::M_NUMBER;
						end else if (jbt_pkg::is_alpha(c)) begin
							pstart_d = p;
							flags_d = jbt_pkg::word_flags(3'b111, '0, c);
							plen_d = jbt_pkg::LengthBits'(1);
							mode_d = jbt_pkg::M_WORD;
						end else begin
							items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_ERROR, p,
								jbt_pkg::LengthBits'(1));
							cnt = cnt + 2'd1;
							mode_d = jbt_pkg::M_ERROR;
						end
					end
				endcase
			end
			if (last) begin
				if (mode_d != jbt_pkg::M_ERROR) begin
					pt = jbt_pkg::pending_token(mode_d, flags_d, pstart_d, plen_d);
					if (pt.hit) begin
						items[cnt] = pt.tok;
						cnt = cnt + 2'd1;
					end
				end
				items[cnt] = jbt_pkg::make_tok(jbt_pkg::K_END, p, '0);
				cnt = cnt + 2'd1;
			end
		end
		for (int i = 0; i < jbt_pkg::MaxResults; i++)
			items[i].last_of_run = (cnt == 2'(i + 1));
		if (last) begin
			mode_d = jbt_pkg::M_IDLE;
			pos_d = '0;
			pstart_d = '0;
			plen_d = '0;
			flags_d = 3'b111;
		end else begin
			pos_d = p + jbt_pkg::OffsetBits'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q <= jbt_pkg::M_IDLE;
			pos_q <= '0;
			pstart_q <= '0;
			plen_q <= '0;
			flags_q <= 3'b111;
		end else begin
			valid_s1 <= take;
			if (valid_s1) begin
				mode_q <= mode_d;
				pos_q <= pos_d;
				pstart_q <= pstart_d;
				plen_q <= plen_d;
				flags_q <= flags_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= item;
	end

	assign busy_s1 = valid_s1;
	assign push.count = valid_s1 ? cnt : 2'd0;
	assign push.items = items;

endmodule

FILE: hdl/jbt_queue.sv
module jbt_queue (
	input logic clk,
	input logic arst_n,
	input jbt_pkg::push_t push,
	output logic [jbt_pkg::FillBits-1:0] fill,
	jbt_out_if.source token_ch
);

	jbt_pkg::out_item_t [jbt_pkg::QueueDepth-1:0] mem_q;
	logic [jbt_pkg::QueueAw-1:0] wp_q;
	logic [jbt_pkg::QueueAw-1:0] rp_q;
	logic [jbt_pkg::FillBits-1:0] fill_q;
	logic pop;

	assign pop = token_ch.valid && token_ch.ready;
	assign token_ch.valid = (fill_q != '0);
	assign token_ch.item = mem_q[rp_q];
	assign fill = fill_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < jbt_pkg::MaxResults; i++) begin
			if (2'(i) < push.count)
				mem_q[wp_q + jbt_pkg::QueueAw'(i)] <= push.items[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
		end else begin
			wp_q <= wp_q + jbt_pkg::QueueAw'(push.count);
			if (pop)
				rp_q <= rp_q + jbt_pkg::QueueAw'(1);
			fill_q <= fill_q + jbt_pkg::FillBits'(push.count) - jbt_pkg::FillBits'(pop);
		end
	end

endmodule

FILE: hdl/jbt_checker.sv
module jbt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input jbt_pkg::out_item_t out_item
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("token item changed while stalled");

	a_end_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.token_kind == jbt_pkg::K_END |->
			out_item.token_length == '0 && out_item.last_of_run)
		else $error("end token with length or not last");

	a_single_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.token_kind == jbt_pkg::K_ERROR
			|| out_item.token_kind == jbt_pkg::K_LBRACE
			|| out_item.token_kind == jbt_pkg::K_RBRACE
			|| out_item.token_kind == jbt_pkg::K_LBRACKET
			|| out_item.token_kind == jbt_pkg::K_RBRACKET
			|| out_item.token_kind == jbt_pkg::K_COMMA
			|| out_item.token_kind == jbt_pkg::K_COLON) |->
			out_item.token_length == jbt_pkg::LengthBits'(1))
		else $error("punctuation or error token without unit length");

	a_literal_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.token_kind == jbt_pkg::K_TRUE
			|| out_item.token_kind == jbt_pkg::K_NULL) |->
			out_item.token_length == jbt_pkg::LengthBits'(4))
		else $error("true or null token of wrong length");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(token_ch.valid),
	.out_ready(token_ch.ready),
	.out_item(token_ch.item)
);
